// File: sv/smjr_pkg.sv
// Shared types and constants of the multi-joint servo ramp.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package smjr_pkg;

  localparam int NUM_JOINTS = 6;
  localparam int JOINT_W    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  localparam int ANGLE_W = 14;   // raw target, 1/16 degree, signed
  localparam int DUR_W   = 16;
  localparam int STEP_W  = 12;
  localparam int CH_W    = 4;
  localparam int OFF_W   = 10;

  // Divider: |diff| * step / steps has a quotient below 2**QUO_W
  localparam int QUO_W   = ANGLE_W;
  localparam int PROD_W  = ANGLE_W + STEP_W;
  localparam int DCNT_W  = $clog2(QUO_W);

  localparam int ANGLE_MAX16 = 4000;   // 250 degrees
  localparam int OFF_BASE    = 102;
  localparam int OFF_SPAN    = 410;
  localparam int SCALED_W    = 21;     // 4000 * 410 fits
  localparam int ARM1_CH     = 9;

  // dur / 20 = ((dur >> 2) * RECIP_5) >> 18, exact for 14-bit operands
  localparam int RECIP_5       = 52429;
  localparam int RECIP_5_SHIFT = 18;
  // n / 2880 = (((n >> 6) * RECIP_45) >> 21), exact for n < 2**21
  localparam int RECIP_45       = 46604;
  localparam int RECIP_45_SHIFT = 21;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIV,
    ST_ANGLE,
    ST_SCALE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic start_move;
    logic advance;
    logic prod;
    logic div_step;
    logic angle;
    logic scale;
    logic next_joint;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic div_last;
    logic joint_last;
  } dp_sts_t;

endpackage

// File: sv/smjr_in_if.sv
// Command channel of the servo ramp: start command or frame tick.
// Depends on smjr_pkg.
interface smjr_in_if
  import smjr_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic                      arm_select;
  logic signed [ANGLE_W-1:0] target_0;
  logic signed [ANGLE_W-1:0] target_1;
  logic signed [ANGLE_W-1:0] target_2;
  logic signed [ANGLE_W-1:0] target_3;
  logic signed [ANGLE_W-1:0] target_4;
  logic signed [ANGLE_W-1:0] target_5;
  logic [DUR_W-1:0]          duration_ms;

  modport source (
    output valid, cmd, arm_select, target_0, target_1, target_2, target_3,
           target_4, target_5, duration_ms,
    input  ready
  );
  modport sink (
    input  valid, cmd, arm_select, target_0, target_1, target_2, target_3,
           target_4, target_5, duration_ms,
    output ready
  );
endinterface

// File: sv/smjr_out_if.sv
// Servo update channel of the servo ramp: one beat per joint on a tick.
// Depends on smjr_pkg.
interface smjr_out_if
  import smjr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             arm_out;
  logic [CH_W-1:0]  channel;
  logic [OFF_W-1:0] off_count;
  logic             last_of_run;

  modport source (
    output valid, arm_out, channel, off_count, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, arm_out, channel, off_count, last_of_run,
    output ready
  );
endinterface

// File: sv/servo_multi_joint_ramp.sv
// Top level of the multi-joint servo ramp: controller plus datapath.
// Depends on smjr_pkg, smjr_in_if, smjr_out_if, smjr_ctrl, smjr_dp.
//
//   channel  dir  beat carries
//   in_ch    in   cmd, arm_select, target_0..5, duration_ms
//   out_ch   out  arm_out, channel, off_count, last_of_run
//
// A start beat, like a tick while no ramp runs, is taken in idle and leaves the sequencer there.
// A tick on a running ramp walks each joint in turn through product,
// 14 divide steps, clamp, scale and one output beat; the shared
// restoring divider yields one quotient bit a cycle.
// Reset (rst_n low, synchronous) clears the ramp and the per-arm history
// flags; no clearing pass is needed. A stall on out_ch holds the beat and
// keeps in_ch not ready until the tick's last joint is taken.
module servo_multi_joint_ramp
  import smjr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  smjr_in_if.sink    in_ch,
  smjr_out_if.source out_ch
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequence each tick joint by joint
  smjr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // Hold the move, divide and scale, drive the output beat
  smjr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .arm_select  (in_ch.arm_select),
    .target_0    (in_ch.target_0),
    .target_1    (in_ch.target_1),
    .target_2    (in_ch.target_2),
    .target_3    (in_ch.target_3),
    .target_4    (in_ch.target_4),
    .target_5    (in_ch.target_5),
    .duration_ms (in_ch.duration_ms),
    .cmd         (dp_cmd),
    .sts         (dp_sts),
    .arm_out     (out_ch.arm_out),
    .channel     (out_ch.channel),
    .off_count   (out_ch.off_count),
    .last_of_run (out_ch.last_of_run)
  );

endmodule

// File: sv/smjr_ctrl.sv
// Sequencer of the servo ramp: walks each joint through product, divide,
// clamp/scale and output. Depends on smjr_pkg.
module smjr_ctrl
  import smjr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_cmd,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_START) begin
            cmd.start_move = 1'b1;
          end else if (sts.active) begin
            cmd.advance = 1'b1;
            state_nxt   = ST_PROD;
          end
        end
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd.angle = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.joint_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_joint = 1'b1;
            state_nxt      = ST_PROD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_cmd == CMD_TICK && sts.active)
      |=> state_r == ST_PROD)
    else $error("active tick did not start the joint walk");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_ready && sts.joint_last) |=> state_r == ST_IDLE)
    else $error("sequencer did not return to idle after the last joint");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_last) |=> state_r == ST_ANGLE)
    else $error("divide did not end on its last quotient bit");

endmodule

// File: sv/smjr_dp.sv
// Datapath of the servo ramp: move storage, step counters, restoring divider
// and angle-to-count scaling. Depends on smjr_pkg.
module smjr_dp
  import smjr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      arm_select,
  input  logic signed [ANGLE_W-1:0] target_0,
  input  logic signed [ANGLE_W-1:0] target_1,
  input  logic signed [ANGLE_W-1:0] target_2,
  input  logic signed [ANGLE_W-1:0] target_3,
  input  logic signed [ANGLE_W-1:0] target_4,
  input  logic signed [ANGLE_W-1:0] target_5,
  input  logic [DUR_W-1:0]          duration_ms,
  input  dp_cmd_t                   cmd,
  output dp_sts_t                   sts,
  output logic                      arm_out,
  output logic [CH_W-1:0]           channel,
  output logic [OFF_W-1:0]          off_count,
  output logic                      last_of_run
);

  localparam int DPROD_W = DUR_W - 2 + 16;
  localparam int MPROD_W = (SCALED_W - 6) + 16;

  logic [ANGLE_W-1:0] tgt [NUM_JOINTS];
  logic [ANGLE_W-1:0] last_tgt_r [2][NUM_JOINTS];
  logic [ANGLE_W-1:0] start_r [NUM_JOINTS];
  logic [ANGLE_W-1:0] goal_r [NUM_JOINTS];
  logic [1:0]         arm_ready_r;
  logic               active_r;
  logic               arm_r;
  logic [STEP_W-1:0]  idx_r, idx_nxt;
  logic [STEP_W-1:0]  total_r;
  logic [JOINT_W-1:0] joint_r;
  logic [DCNT_W-1:0]  dcnt_r;

  logic [STEP_W-1:0]   rem_r;
  logic [QUO_W-1:0]    lo_r;
  logic                neg_r;
  logic [SCALED_W-1:0] scaled_r;
  logic                arm_out_r, last_r;
  logic [CH_W-1:0]     channel_r;
  logic [OFF_W-1:0]    off_r;

  assign tgt[0] = target_0;
  assign tgt[1] = target_1;
  assign tgt[2] = target_2;
  assign tgt[3] = target_3;
  assign tgt[4] = target_4;
  assign tgt[5] = target_5;

  // Step count: duration / 20, at least one
  logic [DPROD_W-1:0] dur_prod;
  logic [STEP_W-1:0]  steps_raw, steps;
  assign dur_prod  = DPROD_W'(duration_ms[DUR_W-1:2]) * DPROD_W'(RECIP_5);
  assign steps_raw = dur_prod[RECIP_5_SHIFT +: STEP_W];
  assign steps     = (steps_raw == '0) ? STEP_W'(1) : steps_raw;
  assign idx_nxt   = idx_r + STEP_W'(1);

  // Product stage: |goal - start| * step, sign kept aside
  logic [ANGLE_W-1:0] cur_start, cur_goal;
  logic [ANGLE_W:0]   diff, mag;
  logic [PROD_W-1:0]  prod;
  assign cur_start = start_r[joint_r];
  assign cur_goal  = goal_r[joint_r];
  assign diff = {cur_goal[ANGLE_W-1], cur_goal} - {cur_start[ANGLE_W-1], cur_start};
  assign mag  = diff[ANGLE_W] ? ((ANGLE_W+1)'(0) - diff) : diff;
  assign prod = PROD_W'(mag[ANGLE_W-1:0]) * PROD_W'(idx_r);

  // Restoring divide, one quotient bit per cycle
  logic [STEP_W:0] trial_in, trial;
  logic            qbit;
  assign trial_in = {rem_r, lo_r[QUO_W-1]};
  assign trial    = trial_in - {1'b0, total_r};
  assign qbit     = (trial_in >= {1'b0, total_r});

  // Angle stage: start + signed quotient, clamp to 0..4000
  logic [15:0]        qs, ang;
  logic [STEP_W-1:0]  ang_c;
  assign qs  = neg_r ? (16'd0 - 16'(lo_r)) : 16'(lo_r);
  assign ang = {{(16-ANGLE_W){cur_start[ANGLE_W-1]}}, cur_start} + qs;
  always_comb begin
    if (ang[15]) begin
      ang_c = '0;
    end else if (ang[14:0] > 15'(ANGLE_MAX16)) begin
      ang_c = STEP_W'(ANGLE_MAX16);
    end else begin
      ang_c = ang[STEP_W-1:0];
    end
  end

  // Scale stage: 102 + floor(scaled / 2880)
  logic [MPROD_W-1:0] mprod;
  assign mprod = MPROD_W'(scaled_r[SCALED_W-1:6]) * MPROD_W'(RECIP_45);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_ready_r <= '0;
      active_r    <= 1'b0;
      arm_r       <= 1'b0;
      idx_r       <= '0;
      total_r     <= '0;
      joint_r     <= '0;
      dcnt_r      <= '0;
    end else begin
      if (cmd.start_move) begin
        arm_ready_r[arm_select] <= 1'b1;
        arm_r    <= arm_select;
        idx_r    <= '0;
        total_r  <= steps;
        active_r <= 1'b1;
      end
      if (cmd.advance) begin
        idx_r    <= idx_nxt;
        active_r <= (idx_nxt < total_r);
        joint_r  <= '0;
      end
      if (cmd.next_joint) begin
        joint_r <= joint_r + JOINT_W'(1);
      end
      if (cmd.prod) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_move) begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
        start_r[j] <= arm_ready_r[arm_select] ? last_tgt_r[arm_select][j] : tgt[j];
        goal_r[j]  <= tgt[j];
        last_tgt_r[arm_select][j] <= tgt[j];
      end
    end
    if (cmd.prod) begin
      rem_r <= prod[PROD_W-1:QUO_W];
      lo_r  <= prod[QUO_W-1:0];
      neg_r <= diff[ANGLE_W];
    end
    if (cmd.div_step) begin
      rem_r <= qbit ? trial[STEP_W-1:0] : trial_in[STEP_W-1:0];
      lo_r  <= {lo_r[QUO_W-2:0], qbit};
    end
    if (cmd.angle) begin
      scaled_r <= SCALED_W'(ang_c) * SCALED_W'(OFF_SPAN);
    end
    if (cmd.scale) begin
      off_r     <= OFF_W'(mprod[RECIP_45_SHIFT +: OFF_W]) + OFF_W'(OFF_BASE);
      arm_out_r <= arm_r;
      channel_r <= CH_W'(joint_r) + (arm_r ? CH_W'(ARM1_CH) : CH_W'(0));
      last_r    <= (joint_r == JOINT_W'(NUM_JOINTS - 1));
    end
  end

  assign sts.active     = active_r;
  assign sts.div_last   = (dcnt_r == DCNT_W'(QUO_W - 1));
  assign sts.joint_last = (joint_r == JOINT_W'(NUM_JOINTS - 1));

  assign arm_out     = arm_out_r;
  assign channel     = channel_r;
  assign off_count   = off_r;
  assign last_of_run = last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < total_r)
    else $error("divider remainder not below the step count");

  assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> idx_r < total_r)
    else $error("running ramp has passed its last step");

endmodule

// File: tb/servo_multi_joint_ramp_tb.sv
// Self-checking testbench for servo_multi_joint_ramp: random and directed start and tick beats,
// a scoreboard class that predicts every servo update, randomly idling sender and receiver.
// Depends on smjr_pkg, smjr_in_if, smjr_out_if and the servo_multi_joint_ramp RTL.
module servo_multi_joint_ramp_tb;
  import smjr_pkg::*;

  localparam int FRAME_MS    = 20;
  localparam int TICK_CYCLES = 1 + 18 * NUM_JOINTS;   // busy time of one tick, no stalls
  localparam int TAIL_CYCLES = TICK_CYCLES + 20;
  localparam int HOLD_CYCLES = 300;                   // long receiver hold-off
  localparam int IDLE_LIMIT  = 4000;                  // cycles with no beat on either channel
  localparam int RANDOM_BEATS = 95;

  // One command beat, as the sender drives it.
  typedef struct packed {
    cmd_code_t                         cmd;
    logic                              arm;
    logic [NUM_JOINTS-1:0][ANGLE_W-1:0] tgt;
    logic [DUR_W-1:0]                  dur;
  } ramp_beat_t;

  // One servo update, as the block returns it.
  typedef struct packed {
    logic             arm;
    logic [CH_W-1:0]  channel;
    logic [OFF_W-1:0] off_count;
    logic             last;
  } servo_update_t;

  // Tracks the ramp state and holds the updates still due from the block.
  class servo_ramp_scoreboard;
    int            last_tgt [2][NUM_JOINTS];
    bit            armed [2];
    int            ramp_from [NUM_JOINTS];
    int            ramp_to [NUM_JOINTS];
    bit            running;
    bit            run_arm;
    int            step_no;
    int            step_cnt;
    servo_update_t due_q [$];
    int            errors;
    int            checked;
    int            moves;
    int            frames;

    function int pending();
      return due_q.size();
    endfunction

    // Off count for a clamped angle in 1/16 degree.
    function logic [OFF_W-1:0] angle_to_off(longint a16);
      longint a;
      a = a16;
      if (a < 0) a = 0;
      if (a > ANGLE_MAX16) a = ANGLE_MAX16;
      return OFF_W'(OFF_BASE + (a * OFF_SPAN) / 2880);
    endfunction

    // Apply one accepted beat; return how many updates it makes due.
    function int note_beat(ramp_beat_t b);
      int            steps;
      int            t;
      longint        diff;
      longint        a16;
      servo_update_t u;
      if (b.cmd == CMD_START) begin
        steps = int'(b.dur) / FRAME_MS;
        for (int j = 0; j < NUM_JOINTS; j++) begin
          t = int'($signed(b.tgt[j]));
          ramp_from[j] = armed[b.arm] ? last_tgt[b.arm][j] : t;
          ramp_to[j] = t;
          last_tgt[b.arm][j] = t;
        end
        armed[b.arm] = 1'b1;
        run_arm = b.arm;
        step_no = 0;
        step_cnt = (steps < 1) ? 1 : steps;
        running = 1'b1;
        moves++;
        return 0;
      end
      if (!running) return 0;
      step_no = (step_no + 1) & 'hFFF;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        diff = longint'(ramp_to[j]) - longint'(ramp_from[j]);
        a16 = longint'(ramp_from[j]) + (diff * step_no) / step_cnt;
        u.arm = run_arm;
        u.channel = CH_W'(j + (run_arm ? ARM1_CH : 0));
        u.off_count = angle_to_off(a16);
        u.last = (j == NUM_JOINTS - 1);
        due_q.push_back(u);
      end
      if (step_no >= step_cnt) running = 1'b0;
      frames++;
      return NUM_JOINTS;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_update(servo_update_t got);
      servo_update_t want;
      checked++;
      if (due_q.size() == 0) begin
        report($sformatf("update ch %0d off %0d with nothing due", got.channel, got.off_count));
      end else begin
        want = due_q.pop_front();
        if (got.arm !== want.arm)
          report($sformatf("arm_out %b, want %b", got.arm, want.arm));
        if (got.channel !== want.channel)
          report($sformatf("channel %0d, want %0d", got.channel, want.channel));
        if (got.off_count !== want.off_count)
          report($sformatf("ch %0d off_count %0d, want %0d", want.channel, got.off_count,
                           want.off_count));
        if (got.last !== want.last)
          report($sformatf("ch %0d last_of_run %b, want %b", want.channel, got.last, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  smjr_in_if  in_ch ();
  smjr_out_if out_ch ();

  servo_multi_joint_ramp dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  servo_ramp_scoreboard sb;

  bit calm;        // when set, neither side idles
  bit hold_req;    // ask the receiver for one long hold-off
  int useful_beats;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: count cycles without a beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d updates still due", idle_cycles,
                 sb.pending());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Monitor: check every accepted servo update against the oldest one due.
  always @(posedge clk) begin
    servo_update_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.arm = out_ch.arm_out;
      got.channel = out_ch.channel;
      got.off_count = out_ch.off_count;
      got.last = out_ch.last_of_run;
      sb.check_update(got);
    end
  end

  // Receiver: draw a stall before each update; serve a long hold-off on request.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 9);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic logic [ANGLE_W-1:0] pick_angle();
    int v;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: v = -4096;
        1: v = 8191;
        2: v = 0;
        3: v = ANGLE_MAX16;
        4: v = ANGLE_MAX16 + 1;
        default: v = -1;
      endcase
    end else begin
      v = int'($urandom_range(0, 12287)) - 4096;
    end
    return v[ANGLE_W-1:0];
  endfunction

  function automatic ramp_beat_t start_beat(logic arm, int a0, int a1, int a2, int a3, int a4,
                                            int a5, int dur);
    ramp_beat_t b;
    b.cmd = CMD_START;
    b.arm = arm;
    b.tgt[0] = a0[ANGLE_W-1:0];
    b.tgt[1] = a1[ANGLE_W-1:0];
    b.tgt[2] = a2[ANGLE_W-1:0];
    b.tgt[3] = a3[ANGLE_W-1:0];
    b.tgt[4] = a4[ANGLE_W-1:0];
    b.tgt[5] = a5[ANGLE_W-1:0];
    b.dur = dur[DUR_W-1:0];
    return b;
  endfunction

  function automatic ramp_beat_t random_start(int dur);
    ramp_beat_t b;
    b.cmd = CMD_START;
    b.arm = 1'($urandom_range(0, 1));
    for (int j = 0; j < NUM_JOINTS; j++) b.tgt[j] = pick_angle();
    b.dur = dur[DUR_W-1:0];
    return b;
  endfunction

  // A tick carries junk in its other fields; the block must ignore it.
  function automatic ramp_beat_t tick_beat();
    ramp_beat_t b;
    b = random_start($urandom_range(0, 65535));
    b.cmd = CMD_TICK;
    return b;
  endfunction

  // Drive one beat after a random gap and hold it until the block takes it.
  task automatic send_beat(ramp_beat_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= b.cmd;
    in_ch.arm_select  <= b.arm;
    in_ch.target_0    <= b.tgt[0];
    in_ch.target_1    <= b.tgt[1];
    in_ch.target_2    <= b.tgt[2];
    in_ch.target_3    <= b.tgt[3];
    in_ch.target_4    <= b.tgt[4];
    in_ch.target_5    <= b.tgt[5];
    in_ch.duration_ms <= b.dur;
    do @(posedge clk); while (!in_ch.ready);
    if (sb.note_beat(b) > 0 || b.cmd == CMD_START) useful_beats++;
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_beat(tick_beat());
  endtask

  // Drop valid and wait until every due update has come back, then let the block settle.
  task automatic drain_updates();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int steps;
    int n;
    int seq_no;
    sb = new;
    calm = 1'b0;
    hold_req = 1'b0;
    useful_beats = 0;
    idle_cycles = 0;
    seq_no = 0;

    // Hold every input at a known value through reset.
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_START;
    in_ch.arm_select  <= 1'b0;
    in_ch.target_0    <= '0;
    in_ch.target_1    <= '0;
    in_ch.target_2    <= '0;
    in_ch.target_3    <= '0;
    in_ch.target_4    <= '0;
    in_ch.target_5    <= '0;
    in_ch.duration_ms <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    // A tick before any move produces nothing.
    send_beat(tick_beat());
    // First move of arm 0: the ramp sits on the targets; range extremes and clamp edges.
    send_beat(start_beat(1'b0, 8191, -4096, 0, ANGLE_MAX16, ANGLE_MAX16 + 1, -1, 60));
    send_ticks(3);
    // The ramp has ended, so this tick is idle.
    send_beat(tick_beat());
    // Duration below one frame gives a single step straight to the new targets.
    send_beat(start_beat(1'b0, -4096, 8191, 2880, 1, ANGLE_MAX16, 0, 19));
    send_ticks(1);
    // First move of arm 1 with zero duration.
    send_beat(start_beat(1'b1, 0, 0, 0, 0, 0, 0, 0));
    send_ticks(1);
    // Longest duration, cut short by a move on the other arm.
    send_beat(start_beat(1'b1, -4096, 8191, -4096, 8191, 2000, 16, 65535));
    send_ticks(2);
    send_beat(start_beat(1'b0, 100, 200, 300, 4095, -100, 3999, 100));
    send_ticks(6);
    drain_updates();

    // Random part: mostly whole moves, some cut short, some noise.
    useful_beats = 0;
    while (useful_beats < RANDOM_BEATS) begin
      seq_no++;
      calm = ($urandom_range(0, 4) == 0);
      if (seq_no == 6) begin
        // Long receiver hold-off while a move keeps the sender busy: the block must stall.
        calm = 1'b1;
        hold_req = 1'b1;
        send_beat(random_start(160));
        send_ticks(8);
        calm = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            send_beat(random_start($urandom_range(0, 180)));
            steps = int'(sb.step_cnt);
            if ($urandom_range(0, 3) == 0) n = $urandom_range(0, steps);
            else n = steps + $urandom_range(0, 2);
            send_ticks(n);
          end
          7: send_ticks(1);
          8: begin
            send_beat(random_start($urandom_range(0, 65535)));
            send_ticks($urandom_range(1, 3));
          end
          default: send_beat(random_start($urandom_range(0, 65535)));
        endcase
      end
      // Pause the sender now and then until every update is back.
      if (seq_no % 7 == 0) drain_updates();
    end

    drain_updates();
    calm = 1'b0;
    if (sb.pending() != 0) sb.report($sformatf("%0d updates never arrived", sb.pending()));
    $display("covered %0d moves, %0d active ticks, %0d servo updates checked", sb.moves,
             sb.frames, sb.checked);
    $display("both arms, clamp edges, one-frame and cancelled moves, stalls on both channels");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/smjr_pkg.sv
sv/smjr_in_if.sv
sv/smjr_out_if.sv
sv/smjr_ctrl.sv
sv/smjr_dp.sv
sv/servo_multi_joint_ramp.sv
tb/servo_multi_joint_ramp_tb.sv
